### design/ssim_pkg.sv
// ssim_pkg: shared types, constants and tables of the SSIM frame comparator
// depends on nothing; used by ssim_ctrl, ssim_dp, ssim_image_compare_top and the bench
package ssim_pkg;

  // window geometry
  localparam int SPAN = 11;
  localparam int MOM  = 5;
  localparam int LAST_VSTEP = SPAN;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;

  // stabilising constants, Q.24
  localparam logic signed [47:0] C1_Q24 = 48'sd109093847;
  localparam logic signed [47:0] C2_Q24 = 48'sd981844623;

  // saturation caps
  localparam logic [22:0] SSIM_CAP  = 23'd16384;
  localparam logic [22:0] PLANE_CAP = 23'd4194304;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_VSTEP, OP_HLAST, OP_NORM,
    OP_MP11, OP_MP22, OP_MP12, OP_P12, OP_FACT, OP_MNUM, OP_MDEN,
    OP_SDIV, OP_SACC, OP_ADV, OP_PDIV, OP_PACC, OP_FDIV, OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [3:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic win_valid;
    logic last_col;
    logic last_row;
    logic last_plane;
    logic count_zero;
    logic div_busy;
    logic out_full;
  } dp_stat_t;

  // gaussian taps, sigma 1.5, Q0.16, normalised over the window
  function automatic logic [14:0] tap_coef(input logic [3:0] idx);
    logic [14:0] t;
    case (idx) inside
      4'd0, 4'd10: t = 15'd67;
      4'd1, 4'd9:  t = 15'd498;
      4'd2, 4'd8:  t = 15'd2359;
      4'd3, 4'd7:  t = 15'd7167;
      4'd4, 4'd6:  t = 15'd13960;
      4'd5:        t = 15'd17433;
      default:     t = 15'd0;
    endcase
    return t;
  endfunction

  function automatic logic signed [47:0] clamp_s48(input logic signed [47:0] v,
                                                   input logic signed [47:0] lo,
                                                   input logic signed [47:0] hi);
    logic signed [47:0] r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

### design/ssim_image_compare_top.sv
// ssim_image_compare_top: SSIM frame comparator, configuration registers and wiring
// depends on ssim_pkg, ssim_ctrl and ssim_dp
//
// Usage: pixel pairs (pixel_a_i, pixel_b_i) enter on the input channel, one
// channel plane after another, each plane in raster order. A word is taken
// when in_valid_i is high and in_stall_o is low. After the last pixel of the
// last plane one word carrying the mean SSIM (Q1.14) leaves on the output
// channel; it is taken when out_valid_o is high and out_stall_i is low.
// Throughput: one pixel at a time. The sequence of a pixel with a full
// 11x11 window is set by the vertical tap steps and the 15-step ratio
// divider; any other pixel skips the ratio. The last pixel of a plane
// also adds the plane mean (23-step division), and the last pixel of
// the frame the frame mean. Configuration registers (width, height,
// channel count) are written through cfg_we_i / cfg_index_i / cfg_data_i;
// the user must write them only while idle, the block does not enforce it.
// Reset clears counters and sums and loads 64 x 64, one channel; line
// stores are not cleared. A stalled result holds the output register; new
// pixels are still taken until the next frame result is due.
module ssim_image_compare_top #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pixel_a_i,
  input  logic [7:0]  pixel_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] ssim_mean_o
);

  logic [11:0] width_q;
  logic [12:0] height_q;
  logic [2:0]  chan_q;
  logic [11:0] width_eff;
  logic [12:0] height_eff;
  logic [2:0]  chan_eff;

  ssim_pkg::dp_cmd_t  cmd;
  ssim_pkg::dp_stat_t stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd64;
      height_q <= 13'd64;
      chan_q   <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ssim_pkg::CFG_FRAME_WIDTH:   width_q  <= cfg_data_i[11:0];
        ssim_pkg::CFG_FRAME_HEIGHT:  height_q <= cfg_data_i;
        ssim_pkg::CFG_CHANNEL_COUNT: chan_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // range limits of the geometry
  always_comb begin
    if (width_q == '0) width_eff = 12'd1;
    else if (32'(width_q) > MAX_WIDTH) width_eff = 12'(MAX_WIDTH);
    else width_eff = width_q;
    if (height_q == '0) height_eff = 13'd1;
    else if (height_q > 13'd4096) height_eff = 13'd4096;
    else height_eff = height_q;
    if (chan_q == '0) chan_eff = 3'd1;
    else if (chan_q > 3'd4) chan_eff = 3'd4;
    else chan_eff = chan_q;
  end

  ssim_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ssim_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .pixel_a_i   (pixel_a_i),
    .pixel_b_i   (pixel_b_i),
    .width_i     (width_eff),
    .height_i    (height_eff),
    .channels_i  (chan_eff),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .ssim_mean_o (ssim_mean_o)
  );

endmodule

### design/ssim_ram.sv
// ssim_ram: generic single write port RAM with registered read
// depends on nothing
module ssim_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### design/ssim_div.sv
// ssim_div: restoring divider, one quotient bit a cycle, with saturation check
// depends on nothing
module ssim_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] dsh_i,
  input  logic [63:0] thr_i,
  input  logic [4:0]  nbits_i,
  output logic        busy_o,
  output logic        sat_o,
  output logic [22:0] quot_o
);

  logic        busy_q;
  logic        first_q;
  logic [4:0]  cnt_q;
  logic [63:0] rem_q;
  logic [63:0] dsh_q;
  logic [63:0] thr_q;
  logic        sat_q;
  logic [22:0] quot_q;
  logic        take;

  assign take = rem_q >= dsh_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      cnt_q   <= '0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      first_q <= 1'b1;
      cnt_q   <= nbits_i;
    end else if (busy_q) begin
      first_q <= 1'b0;
      cnt_q   <= cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      dsh_q  <= dsh_i;
      thr_q  <= thr_i;
      quot_q <= '0;
    end else if (busy_q) begin
      if (first_q) begin
        sat_q <= rem_q >= thr_q;
      end
      if (take) begin
        rem_q <= rem_q - dsh_q;
      end
      quot_q <= {quot_q[21:0], take};
      dsh_q  <= dsh_q >> 1;
    end
  end

  assign busy_o = busy_q;
  assign sat_o  = sat_q;
  assign quot_o = quot_q;

endmodule

### design/ssim_ctrl.sv
// ssim_ctrl: sequencer of the SSIM comparator, issues at most one datapath operation a cycle
// depends on ssim_pkg
module ssim_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ssim_pkg::dp_stat_t stat_i,
  output ssim_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_VSTEP, S_HLAST, S_NORM,
    S_MP11, S_MP22, S_MP12, S_P12, S_FACT, S_MNUM, S_MDEN,
    S_SDIV, S_SWAIT, S_SACC, S_ADV,
    S_PDIV, S_PWAIT, S_PACC, S_FDIV, S_FWAIT, S_OUT
  } state_e;

  state_e     state_q;
  logic [3:0] step_q;
  logic       fend_q;

  // state, step counter and frame end flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      fend_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE:  if (in_valid_i) state_q <= S_READ;
        S_READ: begin
          step_q  <= '0;
          state_q <= S_VSTEP;
        end
        S_VSTEP: begin
          if (step_q == 4'(ssim_pkg::LAST_VSTEP)) begin
            state_q <= S_HLAST;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        S_HLAST: state_q <= S_NORM;
        S_NORM:  state_q <= stat_i.win_valid ? S_MP11 : S_ADV;
        S_MP11:  state_q <= S_MP22;
        S_MP22:  state_q <= S_MP12;
        S_MP12:  state_q <= S_P12;
        S_P12:   state_q <= S_FACT;
        S_FACT:  state_q <= S_MNUM;
        S_MNUM:  state_q <= S_MDEN;
        S_MDEN:  state_q <= S_SDIV;
        S_SDIV:  state_q <= S_SWAIT;
        S_SWAIT: if (!stat_i.div_busy) state_q <= S_SACC;
        S_SACC:  state_q <= S_ADV;
        S_ADV: begin
          if (stat_i.last_col && stat_i.last_row) begin
            fend_q  <= stat_i.last_plane;
            state_q <= stat_i.count_zero ? S_PACC : S_PDIV;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_PDIV:  state_q <= S_PWAIT;
        S_PWAIT: if (!stat_i.div_busy) state_q <= S_PACC;
        S_PACC:  state_q <= fend_q ? S_FDIV : S_IDLE;
        S_FDIV:  state_q <= S_FWAIT;
        S_FWAIT: if (!stat_i.div_busy) state_q <= S_OUT;
        S_OUT:   if (!stat_i.out_full) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // operation for the current state
  always_comb begin
    cmd_o.step = step_q;
    unique case (state_q)
      S_IDLE:  cmd_o.op = in_valid_i ? ssim_pkg::OP_ACCEPT : ssim_pkg::OP_NONE;
      S_VSTEP: cmd_o.op = ssim_pkg::OP_VSTEP;
      S_HLAST: cmd_o.op = ssim_pkg::OP_HLAST;
      S_NORM:  cmd_o.op = ssim_pkg::OP_NORM;
      S_MP11:  cmd_o.op = ssim_pkg::OP_MP11;
      S_MP22:  cmd_o.op = ssim_pkg::OP_MP22;
      S_MP12:  cmd_o.op = ssim_pkg::OP_MP12;
      S_P12:   cmd_o.op = ssim_pkg::OP_P12;
      S_FACT:  cmd_o.op = ssim_pkg::OP_FACT;
      S_MNUM:  cmd_o.op = ssim_pkg::OP_MNUM;
      S_MDEN:  cmd_o.op = ssim_pkg::OP_MDEN;
      S_SDIV:  cmd_o.op = ssim_pkg::OP_SDIV;
      S_SACC:  cmd_o.op = ssim_pkg::OP_SACC;
      S_ADV:   cmd_o.op = ssim_pkg::OP_ADV;
      S_PDIV:  cmd_o.op = ssim_pkg::OP_PDIV;
      S_PACC:  cmd_o.op = ssim_pkg::OP_PACC;
      S_FDIV:  cmd_o.op = ssim_pkg::OP_FDIV;
      S_OUT:   cmd_o.op = stat_i.out_full ? ssim_pkg::OP_NONE : ssim_pkg::OP_OUT;
      default: cmd_o.op = ssim_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

### design/ssim_dp.sv
// ssim_dp: line stores, gaussian moment window, SSIM arithmetic and result register
// depends on ssim_pkg, ssim_ram and ssim_div
module ssim_dp #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssim_pkg::dp_cmd_t  cmd_i,
  output ssim_pkg::dp_stat_t stat_o,
  input  logic [7:0]         pixel_a_i,
  input  logic [7:0]         pixel_b_i,
  input  logic [11:0]        width_i,
  input  logic [12:0]        height_i,
  input  logic [2:0]         channels_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [15:0]        ssim_mean_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int SPAN  = ssim_pkg::SPAN;
  localparam int MOM   = ssim_pkg::MOM;
  localparam logic signed [47:0] C1_R = ssim_pkg::C1_Q24 + 48'sd65536;
  localparam logic signed [47:0] C2_R = ssim_pkg::C2_Q24 + 48'sd65536;

  // position counters
  logic [COL_W-1:0] col_q;
  logic [11:0]      row_q;
  logic [3:0]       slot_q;
  logic [1:0]       plane_q;
  logic [12:0]      col_next;
  logic [12:0]      row_next;
  logic [2:0]       plane_next;

  // window and arithmetic registers
  logic [15:0]        pix_q;
  logic [15:0]        rd [SPAN];
  logic [15:0]        x_q [MOM];
  logic [31:0]        vacc_q [MOM];
  logic [47:0]        hacc_q [MOM];
  logic [31:0]        cw_q [SPAN-1][MOM];
  logic [39:0]        m_q [MOM];
  logic [63:0]        prod_q;
  logic [39:0]        p11_q, p22_q, p12_q;
  logic [23:0]        n1_q, d1_q;
  logic [22:0]        n2mag_q, d2_q;
  logic               n2neg_q;
  logic [46:0]        num_q;
  logic [22:0]        cap_q;
  logic               neg_q;
  logic signed [47:0] plane_sum_q;
  logic signed [47:0] frame_sum_q;
  logic [24:0]        cnt_q;
  logic               out_full_q;
  logic [15:0]        ssim_q;

  logic             accept;
  logic [4:0]       slot_sum;
  logic [3:0]       slot_sel;
  logic [15:0]      pix_sel;
  logic [3:0]       stepm1;
  logic [31:0]      mul_a, mul_b;
  logic [39:0]      p_rnd;
  logic [11:0]      wm;
  logic [12:0]      hm;
  logic [24:0]      cnt_d;
  logic             div_start;
  logic [63:0]      div_num, div_dsh, div_thr;
  logic [4:0]       div_nb;
  logic [22:0]      div_cap;
  logic             div_neg;
  logic             div_busy, div_sat;
  logic [22:0]      div_q;
  logic [22:0]      dval;
  logic signed [23:0] dsv;
  logic [47:0]      plane_mag, frame_mag;
  logic [46:0]      den;
  logic [10:0]      ch_d;
  logic signed [47:0] s1, s2, s12, n1_w, d1_w, n2_w, d2_w, n1_c, d1_c, n2_c, d2_c;

  assign accept     = cmd_i.op == ssim_pkg::OP_ACCEPT;
  assign col_next   = 13'(col_q) + 13'd1;
  assign row_next   = {1'b0, row_q} + 13'd1;
  assign plane_next = {1'b0, plane_q} + 3'd1;

  // line stores, one per window row
  for (genvar g = 0; g < SPAN; g++) begin : g_line
    ssim_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_ram (
      .clk_i   (clk_i),
      .we_i    (accept && slot_q == 4'(g)),
      .waddr_i (col_q),
      .wdata_i ({pixel_b_i, pixel_a_i}),
      .raddr_i (col_q),
      .rdata_o (rd[g])
    );
  end

  // row select for the vertical pass, oldest row first
  always_comb begin
    slot_sum = 5'(slot_q) + 5'd1 + 5'(cmd_i.step);
    slot_sel = (slot_sum >= 5'(SPAN)) ? 4'(slot_sum - 5'(SPAN)) : slot_sum[3:0];
    pix_sel  = (cmd_i.step == 4'(SPAN - 1)) ? pix_q : rd[slot_sel];
    stepm1   = cmd_i.step - 4'd1;
  end

  // valid count of window positions per plane
  always_comb begin
    wm    = width_i - 12'(SPAN - 1);
    hm    = height_i - 13'(SPAN - 1);
    cnt_d = (width_i >= 12'(SPAN) && height_i >= 13'(SPAN)) ? 25'(wm) * 25'(hm) : '0;
  end

  // shared 32x32 multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      ssim_pkg::OP_MP11: begin
        mul_a = m_q[0][31:0];
        mul_b = m_q[0][31:0];
      end
      ssim_pkg::OP_MP22: begin
        mul_a = m_q[1][31:0];
        mul_b = m_q[1][31:0];
      end
      ssim_pkg::OP_MP12: begin
        mul_a = m_q[0][31:0];
        mul_b = m_q[1][31:0];
      end
      ssim_pkg::OP_MNUM: begin
        mul_a = 32'(n1_q);
        mul_b = 32'(n2mag_q);
      end
      ssim_pkg::OP_MDEN: begin
        mul_a = 32'(d1_q);
        mul_b = 32'(d2_q);
      end
      default: ;
    endcase
  end

  assign p_rnd = 40'((prod_q + 64'd8388608) >> 24);

  // the four SSIM factors, rounded to Q.7 and clamped
  always_comb begin
    s1   = $signed({8'b0, m_q[2]}) - $signed({8'b0, p11_q});
    s2   = $signed({8'b0, m_q[3]}) - $signed({8'b0, p22_q});
    s12  = $signed({8'b0, m_q[4]}) - $signed({8'b0, p12_q});
    n1_w = ($signed({7'b0, p12_q, 1'b0}) + C1_R) >>> 17;
    d1_w = ($signed({8'b0, p11_q}) + $signed({8'b0, p22_q}) + C1_R) >>> 17;
    n2_w = ((s12 <<< 1) + C2_R) >>> 17;
    d2_w = (s1 + s2 + C2_R) >>> 17;
    n1_c = ssim_pkg::clamp_s48(n1_w, 48'sd0, 48'sd16777215);
    d1_c = ssim_pkg::clamp_s48(d1_w, 48'sd1, 48'sd16777215);
    n2_c = ssim_pkg::clamp_s48(n2_w, -48'sd8388607, 48'sd8388607);
    d2_c = ssim_pkg::clamp_s48(d2_w, 48'sd1, 48'sd8388607);
  end

  // divider operands for the ratio, the plane mean and the frame mean
  always_comb begin
    den       = prod_q[46:0];
    plane_mag = plane_sum_q[47] ? 48'(-plane_sum_q) : 48'(plane_sum_q);
    frame_mag = frame_sum_q[47] ? 48'(-frame_sum_q) : 48'(frame_sum_q);
    ch_d      = {channels_i, 8'b0};
    div_start = 1'b0;
    div_num   = '0;
    div_dsh   = '0;
    div_thr   = '0;
    div_nb    = 5'd15;
    div_cap   = ssim_pkg::SSIM_CAP;
    div_neg   = 1'b0;
    case (cmd_i.op)
      ssim_pkg::OP_SDIV: begin
        div_start = 1'b1;
        div_num   = (64'(num_q) << 14) + 64'(den >> 1);
        div_dsh   = 64'(den) << 14;
        div_thr   = (64'(den) << 14) + 64'(den);
        div_neg   = n2neg_q;
      end
      ssim_pkg::OP_PDIV: begin
        div_start = 1'b1;
        div_num   = (64'(plane_mag) << 8) + 64'(cnt_q >> 1);
        div_dsh   = 64'(cnt_q) << 22;
        div_thr   = (64'(cnt_q) << 22) + 64'(cnt_q);
        div_nb    = 5'd23;
        div_cap   = ssim_pkg::PLANE_CAP;
        div_neg   = plane_sum_q[47];
      end
      ssim_pkg::OP_FDIV: begin
        div_start = 1'b1;
        div_num   = 64'(frame_mag) + 64'(ch_d >> 1);
        div_dsh   = 64'(ch_d) << 14;
        div_thr   = (64'(ch_d) << 14) + 64'(ch_d);
        div_neg   = frame_sum_q[47];
      end
      default: ;
    endcase
  end

  ssim_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .dsh_i   (div_dsh),
    .thr_i   (div_thr),
    .nbits_i (div_nb),
    .busy_o  (div_busy),
    .sat_o   (div_sat),
    .quot_o  (div_q)
  );

  // signed, saturated quotient
  always_comb begin
    dval = div_sat ? cap_q : div_q;
    dsv  = neg_q ? -$signed({1'b0, dval}) : $signed({1'b0, dval});
  end

  // control state: counters, sums and result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      slot_q      <= '0;
      plane_q     <= '0;
      plane_sum_q <= '0;
      frame_sum_q <= '0;
      out_full_q  <= 1'b0;
    end else begin
      if (out_full_q && !out_stall_i) begin
        out_full_q <= 1'b0;
      end
      case (cmd_i.op)
        ssim_pkg::OP_SACC: plane_sum_q <= plane_sum_q + 48'(dsv);
        ssim_pkg::OP_ADV: begin
          if (stat_o.last_col) begin
            col_q <= '0;
            if (stat_o.last_row) begin
              row_q   <= '0;
              slot_q  <= '0;
              plane_q <= stat_o.last_plane ? 2'd0 : plane_next[1:0];
            end else begin
              row_q  <= row_next[11:0];
              slot_q <= (slot_q == 4'(SPAN - 1)) ? 4'd0 : slot_q + 4'd1;
            end
          end else begin
            col_q <= col_next[COL_W-1:0];
          end
        end
        ssim_pkg::OP_PACC: begin
          plane_sum_q <= '0;
          if (cnt_q != '0) begin
            frame_sum_q <= frame_sum_q + 48'(dsv);
          end
        end
        ssim_pkg::OP_OUT: begin
          frame_sum_q <= '0;
          out_full_q  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    if (div_start) begin
      cap_q <= div_cap;
      neg_q <= div_neg;
    end
    case (cmd_i.op)
      ssim_pkg::OP_ACCEPT: begin
        pix_q <= {pixel_b_i, pixel_a_i};
        for (int k = 0; k < MOM; k++) begin
          vacc_q[k] <= '0;
          hacc_q[k] <= '0;
        end
      end
      ssim_pkg::OP_VSTEP: begin
        // moments of the selected row, then tap weighting in the following cycle
        x_q[0] <= 16'(pix_sel[7:0]);
        x_q[1] <= 16'(pix_sel[15:8]);
        x_q[2] <= 16'(pix_sel[7:0]) * 16'(pix_sel[7:0]);
        x_q[3] <= 16'(pix_sel[15:8]) * 16'(pix_sel[15:8]);
        x_q[4] <= 16'(pix_sel[7:0]) * 16'(pix_sel[15:8]);
        for (int k = 0; k < MOM; k++) begin
          if (cmd_i.step != 4'd0) begin
            vacc_q[k] <= vacc_q[k] + 32'(ssim_pkg::tap_coef(stepm1)) * 32'(x_q[k]);
          end
          if (cmd_i.step < 4'(SPAN - 1)) begin
            hacc_q[k] <= hacc_q[k]
                         + 48'(ssim_pkg::tap_coef(cmd_i.step)) * 48'(cw_q[cmd_i.step][k]);
          end
        end
      end
      ssim_pkg::OP_HLAST: begin
        for (int k = 0; k < MOM; k++) begin
          hacc_q[k] <= hacc_q[k]
                       + 48'(ssim_pkg::tap_coef(4'(SPAN - 1))) * 48'(vacc_q[k]);
        end
      end
      ssim_pkg::OP_NORM: begin
        // round to Q.24 and shift the column window
        for (int k = 0; k < MOM; k++) begin
          m_q[k] <= 40'((hacc_q[k] + 48'd128) >> 8);
          for (int j = 0; j < SPAN - 2; j++) begin
            cw_q[j][k] <= cw_q[j+1][k];
          end
          cw_q[SPAN-2][k] <= vacc_q[k];
        end
      end
      ssim_pkg::OP_MP22: p11_q <= p_rnd;
      ssim_pkg::OP_MP12: p22_q <= p_rnd;
      ssim_pkg::OP_P12:  p12_q <= p_rnd;
      ssim_pkg::OP_FACT: begin
        n1_q    <= n1_c[23:0];
        d1_q    <= d1_c[23:0];
        n2neg_q <= n2_c[47];
        n2mag_q <= n2_c[47] ? 23'(-n2_c) : n2_c[22:0];
        d2_q    <= d2_c[22:0];
      end
      ssim_pkg::OP_MDEN: num_q <= prod_q[46:0];
      ssim_pkg::OP_OUT:  ssim_q <= 16'(dsv);
      default: ;
    endcase
    case (cmd_i.op)
      ssim_pkg::OP_MP11, ssim_pkg::OP_MP22, ssim_pkg::OP_MP12,
      ssim_pkg::OP_MNUM, ssim_pkg::OP_MDEN: prod_q <= mul_a * mul_b;
      default: ;
    endcase
  end

  // status towards the sequencer
  always_comb begin
    stat_o.win_valid  = row_q >= 12'(SPAN - 1) && col_q >= COL_W'(SPAN - 1);
    stat_o.last_col   = col_next >= {1'b0, width_i};
    stat_o.last_row   = row_next >= height_i;
    stat_o.last_plane = plane_next >= channels_i;
    stat_o.count_zero = cnt_q == '0;
    stat_o.div_busy   = div_busy;
    stat_o.out_full   = out_full_q;
  end

  assign out_valid_o = out_full_q;
  assign ssim_mean_o = ssim_q;

endmodule

### bench/tb_ssim_image_compare_top.sv
// tb_ssim_image_compare_top: self-checking bench of the SSIM frame comparator
// depends on ssim_pkg and ssim_image_compare_top; predicts each frame mean itself
`timescale 1ns / 1ps

module tb_ssim_image_compare_top;
  import ssim_pkg::*;

  localparam int  WIDTH_MAX   = 2048;
  localparam int  HEIGHT_MAX  = 4096;
  localparam int  SETTLE      = 200;
  localparam longint CYCLE_LIMIT = 64'd9000000;

  typedef enum int {PAT_RANDOM, PAT_NOISY, PAT_SAME, PAT_INVERT, PAT_EXTREME, PAT_FLAT} pattern_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = CFG_FRAME_WIDTH;
  logic [12:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  pixel_a_i = '0;
  logic [7:0]  pixel_b_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] ssim_mean_o;

  ssim_image_compare_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .pixel_a_i, .pixel_b_i,
    .out_valid_o, .out_stall_i, .ssim_mean_o
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0]     pair_rows [0:SPAN-1][0:WIDTH_MAX-1];
  longint unsigned tap_q16 [0:SPAN-1];
  int              geo_w = 64, geo_h = 64, geo_ch = 1;
  int              col_pos = 0, row_pos = 0, plane_no = 0;
  longint          plane_sum = 0, frame_sum = 0;
  logic [15:0]     mean_q [$];

  int     errors = 0;
  bit     idle_on = 1'b1;
  longint cycles = 0;
  int     stall_left = 0;

  // gaussian taps in Q0.16, normalised over the window
  task automatic build_taps();
    longint unsigned g [0:7];
    longint unsigned s;
    int d;
    g = '{64'd16777216, 64'd13434144, 64'd6897320, 64'd2270548,
          64'd479250, 64'd64859, 64'd5628, 64'd313};
    s = 0;
    for (int i = 0; i < SPAN; i++) begin
      d = (i < SPAN / 2) ? SPAN / 2 - i : i - SPAN / 2;
      s += g[d];
    end
    for (int i = 0; i < SPAN; i++) begin
      d = (i < SPAN / 2) ? SPAN / 2 - i : i - SPAN / 2;
      tap_q16[i] = (g[d] * 64'd65536 + s / 2) / s;
    end
  endtask

  function automatic longint unsigned mul_q24(longint unsigned x, longint unsigned y);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    p = (p + 128'd8388608) >> 24;
    return p[63:0];
  endfunction

  function automatic longint round_q7(longint v);
    return (v + 64'sd65536) >>> 17;
  endfunction

  function automatic longint limit(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint div_round(longint n, longint unsigned d);
    longint unsigned mag, q;
    mag = n < 0 ? longint'(-n) : longint'(n);
    q = (mag + d / 2) / d;
    return n < 0 ? -longint'(q) : longint'(q);
  endfunction

  // ssim in Q1.14 of the window ending at (c, r)
  function automatic longint window_ssim(int c, int r);
    longint unsigned acc [5];
    longint unsigned hs [5];
    longint unsigned mo [5];
    longint unsigned a, b, t, p11, p22, p12, num, den, q;
    longint s1, s2, s12, n1, d1, n2, d2;
    logic [15:0] pr;
    for (int k = 0; k < 5; k++) acc[k] = 0;
    for (int i = 0; i < SPAN; i++) begin
      for (int k = 0; k < 5; k++) hs[k] = 0;
      for (int j = 0; j < SPAN; j++) begin
        pr = pair_rows[(r - (SPAN - 1) + i) % SPAN][c - (SPAN - 1) + j];
        a = pr[7:0];
        b = pr[15:8];
        t = tap_q16[j];
        hs[0] += t * a;
        hs[1] += t * b;
        hs[2] += t * a * a;
        hs[3] += t * b * b;
        hs[4] += t * a * b;
      end
      for (int k = 0; k < 5; k++) acc[k] += tap_q16[i] * hs[k];
    end
    for (int k = 0; k < 5; k++) mo[k] = (acc[k] + 128) >> 8;
    p11 = mul_q24(mo[0], mo[0]);
    p22 = mul_q24(mo[1], mo[1]);
    p12 = mul_q24(mo[0], mo[1]);
    s1  = longint'(mo[2]) - longint'(p11);
    s2  = longint'(mo[3]) - longint'(p22);
    s12 = longint'(mo[4]) - longint'(p12);
    n1 = limit(round_q7(2 * longint'(p12) + longint'(C1_Q24)), 0, (64'sd1 << 24) - 1);
    d1 = limit(round_q7(longint'(p11) + longint'(p22) + longint'(C1_Q24)), 1,
               (64'sd1 << 24) - 1);
    n2 = limit(round_q7(2 * s12 + longint'(C2_Q24)), -((64'sd1 << 23) - 1),
               (64'sd1 << 23) - 1);
    d2 = limit(round_q7(s1 + s2 + longint'(C2_Q24)), 1, (64'sd1 << 23) - 1);
    num = longint'(n1) * longint'(n2 < 0 ? -n2 : n2);
    den = longint'(d1) * longint'(d2);
    q = ((num << 14) + den / 2) / den;
    if (q > 16384) q = 16384;
    return n2 < 0 ? -longint'(q) : longint'(q);
  endfunction

  // advance the predictor by one accepted pixel pair
  task automatic predict_pixel(logic [7:0] a, logic [7:0] b);
    longint unsigned count;
    longint mean, res;
    pair_rows[row_pos % SPAN][col_pos] = {b, a};
    if (row_pos >= SPAN - 1 && col_pos >= SPAN - 1)
      plane_sum += window_ssim(col_pos, row_pos);
    col_pos++;
    if (col_pos >= geo_w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= geo_h) begin
        row_pos = 0;
        count = longint'(geo_w - (SPAN - 1)) * longint'(geo_h - (SPAN - 1));
        mean = limit(div_round(plane_sum * 256, count), -(64'sd1 << 22), 64'sd1 << 22);
        frame_sum += mean;
        plane_sum = 0;
        plane_no++;
        if (plane_no >= geo_ch) begin
          res = limit(div_round(frame_sum, longint'(geo_ch) * 256), -16384, 16384);
          mean_q.push_back(res[15:0]);
          frame_sum = 0;
          plane_no = 0;
        end
      end
    end
  endtask

  // register write, block idle
  task automatic write_reg(logic [1:0] idx, int value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value[12:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:   geo_w = value;
      CFG_FRAME_HEIGHT:  geo_h = value;
      CFG_CHANNEL_COUNT: geo_ch = value;
      default: ;
    endcase
  endtask

  // one word on the input channel
  task automatic send_pixel(logic [7:0] a, logic [7:0] b);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    pixel_a_i = a;
    pixel_b_i = b;
    do @(posedge clk_i); while (in_stall_o);
    predict_pixel(a, b);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (mean_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // one whole frame with the given geometry and pixel pattern
  task automatic run_frame(int w, int h, int ch, pattern_e pat);
    logic [7:0] a, b, fa, fb;
    int n;
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_CHANNEL_COUNT, ch);
    fa = $urandom;
    fb = $urandom;
    for (int i = 0; i < w * h * ch; i++) begin
      a = $urandom;
      b = $urandom;
      case (pat)
        PAT_NOISY: begin
          n = int'(a) + $urandom_range(0, 40) - 20;
          b = n < 0 ? 8'd0 : (n > 255 ? 8'd255 : n[7:0]);
        end
        PAT_SAME:    b = a;
        PAT_INVERT:  b = ~a;
        PAT_EXTREME: begin
          a = a[0] ? 8'hFF : 8'h00;
          b = b[0] ? 8'hFF : 8'h00;
        end
        PAT_FLAT: begin
          a = fa;
          b = fb;
        end
        default: ;
      endcase
      send_pixel(a, b);
    end
    wait_idle();
  endtask

  // result checker and output stall
  task automatic note_mismatch(logic [15:0] exp_v, logic [15:0] got_v, bit orphan);
    errors++;
    if (errors <= 10) begin
      if (orphan) $display("ssim mean %0d with nothing expected", $signed(got_v));
      else $display("ssim mean mismatch: expected %0d got %0d",
                    $signed(exp_v), $signed(got_v));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (mean_q.size() == 0) note_mismatch('0, ssim_mean_o, 1'b1);
      else if (mean_q[0] !== ssim_mean_o) note_mismatch(mean_q.pop_front(), ssim_mean_o, 1'b0);
      else void'(mean_q.pop_front());
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_ssim_image_compare_top: errors");
      $finish;
    end
  end

  // test tasks
  task automatic test_reset_geometry();
    for (int i = 0; i < 64 * 64; i++) send_pixel($urandom, $urandom);
    wait_idle();
  endtask

  task automatic test_smallest_frame();
    run_frame(SPAN, SPAN, 1, PAT_EXTREME);
    run_frame(SPAN, SPAN, 1, PAT_FLAT);
  endtask

  task automatic test_identical_and_inverse();
    run_frame(12, SPAN, 2, PAT_SAME);
    run_frame(SPAN, 13, 1, PAT_INVERT);
  endtask

  task automatic test_all_channels();
    run_frame(SPAN, SPAN, 4, PAT_NOISY);
    run_frame(13, 12, 3, PAT_RANDOM);
  endtask

  task automatic test_widest_and_tallest();
    run_frame(WIDTH_MAX, SPAN, 1, PAT_NOISY);
    run_frame(SPAN, HEIGHT_MAX, 1, PAT_NOISY);
  endtask

  task automatic test_random_frames();
    pattern_e pat;
    for (int f = 0; f < 44; f++) begin
      if (f >= 38) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        0:       pat = PAT_RANDOM;
        1:       pat = PAT_EXTREME;
        2:       pat = PAT_INVERT;
        3:       pat = PAT_SAME;
        default: pat = PAT_NOISY;
      endcase
      run_frame($urandom_range(SPAN, 16), $urandom_range(SPAN, 15),
                $urandom_range(0, 3) == 0 ? $urandom_range(2, 4) : 1, pat);
    end
  endtask

  initial begin
    build_taps();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_geometry();
    test_smallest_frame();
    test_identical_and_inverse();
    test_all_channels();
    test_widest_and_tallest();
    test_random_frames();
    if (errors == 0 && mean_q.size() == 0) begin
      $display("tb_ssim_image_compare_top: clean");
    end else begin
      $display("tb_ssim_image_compare_top: errors");
    end
    $finish;
  end

endmodule
